// File: rtl/core/hourly_top_bottom_k_tracker_macros.svh
// Assertion macros for the tracker RTL.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef HOURLY_TOP_BOTTOM_K_TRACKER_MACROS_SVH
`define HOURLY_TOP_BOTTOM_K_TRACKER_MACROS_SVH

`ifndef SYNTH
`define HTBK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HTBK_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define HTBK_ASSERT(lbl, prop, msg)
`define HTBK_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/core/htbk_pkg.sv
// Types and constants for the hourly top/bottom-K tracker.
// No dependencies; imported by every tracker module.
package htbk_pkg;

	localparam int TEMP_W = 8;
	localparam int HOUR_W = 8;
	localparam int RANK_W = 3;

	localparam logic LIST_HIGH = 1'b0;
	localparam logic LIST_LOW  = 1'b1;

	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_END_HOUR = 1'b1;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef struct packed {
		logic  kind;
		temp_t temperature;
	} sample_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour_number;
		logic              list_kind;
		logic [RANK_W-1:0] rank;
		temp_t             value;
		logic              valid_res;
		logic              last;
	} report_t;

	typedef struct packed {
		logic  vld;
		temp_t val;
	} slot_t;

	typedef struct packed {
		logic              emit;
		logic              list_kind;
		logic [RANK_W-1:0] rank;
		temp_t             value;
		logic              valid_res;
		logic              last;
	} rpt_ent_t;

endpackage

// File: rtl/core/hourly_top_bottom_k_tracker.sv
// Hourly tracker of the KEEP_COUNT largest and smallest signed readings.
// Top level; uses htbk_pkg, htbk_sort_cell, htbk_rpt_cell and the macro header.
//
// Input channel sample/sample_valid/sample_stall: a reading (kind 0) or an
// end-of-hour mark (kind 1). Readings are taken every cycle; each one is
// compared against all held entries at once and inserted at the following clock edge.
// An end-of-hour mark copies both lists into the report chain, clears them
// and advances the hour in the same cycle, so readings of the next hour
// flow on while the report drains. A further end-of-hour mark is stalled
// until the previous report has fully left.
// Output channel report/report_valid/report_stall: the high list, then the
// low list, both ascending, last set on the final item. With n >= 1 readings
// kept, the empty high slots at the head of the chain are skipped first, and
// the items follow one per cycle while report_stall is low; the chain of
// 2*KEEP_COUNT slots shifts one slot per cycle unless a head item is stalled.
// An empty hour gives one item with valid_res low in the cycle after the mark.
// A stall on the report side holds the chain while the head slot has an item.
// Reset empties both lists, the report chain and the hour counter.
`include "hourly_top_bottom_k_tracker_macros.svh"

module hourly_top_bottom_k_tracker #(
	parameter int KEEP_COUNT = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  htbk_pkg::sample_t sample,
	input  logic              sample_valid,
	output logic              sample_stall,
	output htbk_pkg::report_t report,
	output logic              report_valid,
	input  logic              report_stall
);
	import htbk_pkg::*;

	localparam int CNT_W = $clog2(KEEP_COUNT + 1);
	localparam int RPT_N = 2 * KEEP_COUNT;

	logic               sample_acc;
	logic               take_reading;
	logic               end_hour;
	logic [CNT_W-1:0]   filled_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [HOUR_W-1:0]  rpt_hour_q;
	logic               rpt_busy;
	logic               rpt_shift;
	logic               rpt_done;

	slot_t              low_slot [KEEP_COUNT];
	slot_t              high_slot [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] low_take;
	logic [KEEP_COUNT-1:0] high_take;
	logic [KEEP_COUNT-1:0] low_vld_w;
	logic [KEEP_COUNT-1:0] high_vld_w;

	rpt_ent_t           rpt_ent [RPT_N];
	rpt_ent_t           rpt_load [RPT_N];
	logic [RPT_N-1:0]   rpt_emit_w;

	assign sample_stall = rpt_busy && (sample.kind == KIND_END_HOUR);
	assign sample_acc   = sample_valid && !sample_stall;
	assign take_reading = sample_acc && (sample.kind == KIND_READING);
	assign end_hour     = sample_acc && (sample.kind == KIND_END_HOUR);

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_keep
		slot_t low_up;
		logic  low_up_take;
		slot_t high_up;
		logic  high_up_take;

		if (i == 0) begin : g_low_edge
			assign low_up      = '0;
			assign low_up_take = 1'b0;
		end else begin : g_low_mid
			assign low_up      = low_slot[i-1];
			assign low_up_take = low_take[i-1];
		end

		if (i == KEEP_COUNT - 1) begin : g_high_edge
			assign high_up      = '0;
			assign high_up_take = 1'b0;
		end else begin : g_high_mid
			assign high_up      = high_slot[i+1];
			assign high_up_take = high_take[i+1];
		end

		htbk_sort_cell #(.KEEP_HIGH(1'b0)) u_low (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins        (take_reading),
			.clr        (end_hour),
			.sample_val (sample.temperature),
			.up         (low_up),
			.up_take    (low_up_take),
			.take       (low_take[i]),
			.slot_q     (low_slot[i])
		);

		htbk_sort_cell #(.KEEP_HIGH(1'b1)) u_high (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins        (take_reading),
			.clr        (end_hour),
			.sample_val (sample.temperature),
			.up         (high_up),
			.up_take    (high_up_take),
			.take       (high_take[i]),
			.slot_q     (high_slot[i])
		);

		assign low_vld_w[i]  = low_slot[i].vld;
		assign high_vld_w[i] = high_slot[i].vld;

		// high list sits right-aligned: rank counts from the first filled slot
		always_comb begin
			rpt_load[i].emit      = high_slot[i].vld;
			rpt_load[i].list_kind = LIST_HIGH;
			rpt_load[i].rank      = RANK_W'(i + int'(filled_q) - KEEP_COUNT);
			rpt_load[i].value     = high_slot[i].val;
			rpt_load[i].valid_res = 1'b1;
			rpt_load[i].last      = 1'b0;
			if (i == 0 && filled_q == '0) begin
				rpt_load[i].emit      = 1'b1;
				rpt_load[i].rank      = '0;
				rpt_load[i].value     = '0;
				rpt_load[i].valid_res = 1'b0;
				rpt_load[i].last      = 1'b1;
			end
		end

		always_comb begin
			rpt_load[KEEP_COUNT+i].emit      = low_slot[i].vld;
			rpt_load[KEEP_COUNT+i].list_kind = LIST_LOW;
			rpt_load[KEEP_COUNT+i].rank      = RANK_W'(i);
			rpt_load[KEEP_COUNT+i].value     = low_slot[i].val;
			rpt_load[KEEP_COUNT+i].valid_res = 1'b1;
			rpt_load[KEEP_COUNT+i].last      = (filled_q == CNT_W'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			hour_q   <= '0;
		end else if (end_hour) begin
			filled_q <= '0;
			hour_q   <= hour_q + 1'b1;
		end else if (take_reading && filled_q != CNT_W'(KEEP_COUNT)) begin
			filled_q <= filled_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (end_hour) begin
			rpt_hour_q <= hour_q;
		end
	end

	// drain the chain: skip empty head slots, hold while the head is stalled
	assign rpt_shift = rpt_busy && (!rpt_ent[0].emit || !report_stall);
	assign rpt_busy  = |rpt_emit_w;

	for (genvar j = 0; j < RPT_N; j++) begin : g_rpt
		rpt_ent_t next_ent;

		if (j == RPT_N - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_mid
			assign next_ent = rpt_ent[j+1];
		end

		htbk_rpt_cell u_rpt (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (end_hour),
			.shift    (rpt_shift),
			.load_ent (rpt_load[j]),
			.next_ent (next_ent),
			.ent_q    (rpt_ent[j])
		);

		assign rpt_emit_w[j] = rpt_ent[j].emit;
	end

	assign report_valid       = rpt_ent[0].emit;
	assign report.hour_number = rpt_hour_q;
	assign report.list_kind   = rpt_ent[0].list_kind;
	assign report.rank        = rpt_ent[0].rank;
	assign report.value       = rpt_ent[0].value;
	assign report.valid_res   = rpt_ent[0].valid_res;
	assign report.last        = rpt_ent[0].last;

	assign rpt_done = report_valid && !report_stall && report.last;

	`HTBK_ASSERT(a_low_fill, $countones(low_vld_w) == int'(filled_q), "low list fill mismatch")
	`HTBK_ASSERT(a_high_fill, $countones(high_vld_w) == int'(filled_q), "high list fill mismatch")
	`HTBK_ASSERT(a_hour_adv, end_hour |=> filled_q == '0 && hour_q == $past(hour_q) + 1'b1, "no step")
	`HTBK_NEVER(a_last_drains, $past(rpt_done) && rpt_busy, "report chain busy after last item")

endmodule

// File: rtl/core/htbk_sort_cell.sv
// One entry of a sorted keep list; inserts by handing entries to the next cell.
// Depends on htbk_pkg.
module htbk_sort_cell #(
	parameter bit KEEP_HIGH = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ins,
	input  logic             clr,
	input  htbk_pkg::temp_t  sample_val,
	input  htbk_pkg::slot_t  up,
	input  logic             up_take,
	output logic             take,
	output htbk_pkg::slot_t  slot_q
);
	import htbk_pkg::*;

	logic beats;

	assign beats = KEEP_HIGH ? (sample_val > slot_q.val) : (sample_val < slot_q.val);
	assign take  = !slot_q.vld || beats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (clr) begin
			slot_q.vld <= 1'b0;
		end else if (ins && take) begin
			if (up_take) begin
				slot_q <= up;
			end else begin
				slot_q.vld <= 1'b1;
				slot_q.val <= sample_val;
			end
		end
	end

endmodule

// File: rtl/core/htbk_rpt_cell.sv
// One slot of the report drain chain: loads a snapshot, then shifts toward the head.
// Depends on htbk_pkg.
module htbk_rpt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               shift,
	input  htbk_pkg::rpt_ent_t load_ent,
	input  htbk_pkg::rpt_ent_t next_ent,
	output htbk_pkg::rpt_ent_t ent_q
);
	import htbk_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (load) begin
			ent_q <= load_ent;
		end else if (shift) begin
			ent_q <= next_ent;
		end
	end

endmodule
